FILE: design/as_path_stream_analyzer_assert.svh
// Assertion macros shared by the AS path stream analyzer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef AS_PATH_STREAM_ANALYZER_ASSERT_SVH
`define AS_PATH_STREAM_ANALYZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/asp_pkg.sv
// Shared types and constants of the AS path stream analyzer.
// No dependencies; imported by every module of the block.
package asp_pkg;

    // Error codes reported with a result.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HDR_CUT  = 3'd1;
    localparam logic [2:0] ERR_BODY_CUT = 3'd2;
    localparam logic [2:0] ERR_CONFED   = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd4;
    localparam logic [2:0] ERR_ZERO_LEN = 3'd5;

    // Segment type codes.
    localparam logic [7:0] SEG_SET        = 8'd1;
    localparam logic [7:0] SEG_SEQ        = 8'd2;
    localparam logic [7:0] SEG_CONFED_SEQ = 8'd3;
    localparam logic [7:0] SEG_CONFED_SET = 8'd4;

    // Configuration register indexes.
    localparam logic CFG_ASN_SIZE_FOUR  = 1'b0;
    localparam logic CFG_CONFED_ALLOWED = 1'b1;

    // Largest value an offset field can carry.
    localparam int OFFSET_FIELD_MAX = 8191;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } t_in_item;

    // Members run from the highest bit down, so path_ok lands in bit 0.
    typedef struct packed {
        logic        has_as4;
        logic        has_confed;
        logic [31:0] first_as;
        logic        first_found;
        logic [31:0] origin_as;
        logic        origin_found;
        logic [12:0] path_length;
        logic [12:0] error_value;
        logic [12:0] error_offset;
        logic [2:0]  error_code;
        logic        path_ok;
    } t_result;

endpackage

FILE: design/asp_in_stage.sv
// Input register of the AS path stream analyzer.
// Depends on asp_pkg for the input item type.
module asp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  asp_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output asp_pkg::t_in_item o_item
);
    import asp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The register frees up in the same cycle the parser takes its item.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: design/asp_parse_core.sv
// Per-byte AS_PATH parser: path state, configuration registers and result logic.
// Depends on asp_pkg for codes, the input item type and the result type.
module asp_parse_core #(
    parameter int MAX_PATH_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic              i_cfg_wdata,
    input  logic              i_advance,
    input  asp_pkg::t_in_item i_item,
    output asp_pkg::t_result  o_result
);
    import asp_pkg::*;

    localparam int SAT_INT = (MAX_PATH_BYTES < OFFSET_FIELD_MAX) ?
                             MAX_PATH_BYTES : OFFSET_FIELD_MAX;
    localparam logic [12:0] SAT_CAP = 13'(SAT_INT);

    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    // Offset of the first ASN's last byte in a path that opens with a sequence.
    localparam logic [12:0] FIRST_END_AS2 = 13'd3;
    localparam logic [12:0] FIRST_END_AS4 = 13'd5;

    logic        r_asn_size_four, r_confed_allowed;
    logic [1:0]  r_phase,          n_phase;
    logic [7:0]  r_segment_type,   n_segment_type;
    logic [9:0]  r_asn_bytes_left, n_asn_bytes_left;
    logic [1:0]  r_asn_byte_index, n_asn_byte_index;
    logic [31:0] r_asn_shift,      n_asn_shift;
    logic [12:0] r_byte_offset,    n_byte_offset;
    logic [12:0] r_segment_start,  n_segment_start;
    logic [2:0]  r_pending_error,  n_pending_error;
    logic [7:0]  r_pending_value,  n_pending_value;
    logic [2:0]  r_latched_error,  n_latched_error;
    logic [12:0] r_latched_value,  n_latched_value;
    logic [12:0] r_latched_offset, n_latched_offset;
    logic [12:0] r_length_sum,     n_length_sum;
    logic [31:0] r_origin_reg,     n_origin_reg;
    logic        r_origin_flag,    n_origin_flag;
    logic [31:0] r_first_reg,      n_first_reg;
    logic        r_first_flag,     n_first_flag;
    logic        r_confed_flag,    n_confed_flag;
    logic        r_as4_flag,       n_as4_flag;

    always_comb begin
        logic [7:0]  b;
        logic [12:0] cur;
        logic [2:0]  seg_err;
        logic [7:0]  add_len;
        logic [13:0] len_sum;
        logic        asn_close;
        logic [31:0] asn_val;

        n_phase          = r_phase;
        n_segment_type   = r_segment_type;
        n_asn_bytes_left = r_asn_bytes_left;
        n_asn_byte_index = r_asn_byte_index;
        n_asn_shift      = r_asn_shift;
        n_byte_offset    = r_byte_offset;
        n_segment_start  = r_segment_start;
        n_pending_error  = r_pending_error;
        n_pending_value  = r_pending_value;
        n_latched_error  = r_latched_error;
        n_latched_value  = r_latched_value;
        n_latched_offset = r_latched_offset;
        n_length_sum     = r_length_sum;
        n_origin_reg     = r_origin_reg;
        n_origin_flag    = r_origin_flag;
        n_first_reg      = r_first_reg;
        n_first_flag     = r_first_flag;
        n_confed_flag    = r_confed_flag;
        n_as4_flag       = r_as4_flag;

        b         = i_item.data_byte;
        cur       = r_byte_offset;
        seg_err   = ERR_NONE;
        add_len   = '0;
        len_sum   = '0;
        asn_close = 1'b0;
        asn_val   = '0;

        if (i_item.has_byte) begin
            n_byte_offset = (cur < SAT_CAP) ? cur + 13'd1 : SAT_CAP;
            unique case (r_phase)
                PH_COUNT: begin
                    case (r_segment_type) inside
                        SEG_SET, SEG_SEQ:               seg_err = ERR_NONE;
                        SEG_CONFED_SEQ, SEG_CONFED_SET: seg_err = r_confed_allowed ?
                                                                  ERR_NONE : ERR_CONFED;
                        default:                        seg_err = ERR_UNKNOWN;
                    endcase
                    if (seg_err == ERR_NONE && b == 8'd0) begin
                        seg_err = ERR_ZERO_LEN;
                    end
                    // A set counts one even when empty; a sequence counts its ASNs.
                    if (r_segment_type == SEG_SET) begin
                        add_len = 8'd1;
                    end else if (r_segment_type == SEG_SEQ) begin
                        add_len = b;
                    end
                    len_sum      = {1'b0, r_length_sum} + {6'd0, add_len};
                    n_length_sum = (len_sum < {1'b0, SAT_CAP}) ? len_sum[12:0] : SAT_CAP;
                    if (b != 8'd0 && (r_segment_type == SEG_SET ||
                                      r_segment_type == SEG_CONFED_SET)) begin
                        n_origin_flag = 1'b0;
                    end
                    n_asn_byte_index = '0;
                    n_asn_shift      = '0;
                    if (b == 8'd0) begin
                        if (n_latched_error == ERR_NONE && seg_err != ERR_NONE) begin
                            n_latched_error  = seg_err;
                            n_latched_value  = {5'd0, r_segment_type};
                            n_latched_offset = r_segment_start;
                        end
                        n_pending_error  = ERR_NONE;
                        n_pending_value  = '0;
                        n_asn_bytes_left = '0;
                        n_phase          = PH_TYPE;
                    end else begin
                        n_pending_error  = seg_err;
                        n_pending_value  = r_segment_type;
                        n_asn_bytes_left = r_asn_size_four ? {b, 2'b00} : {1'b0, b, 1'b0};
                        n_phase          = PH_BODY;
                    end
                end
                PH_BODY: begin
                    asn_val = {r_asn_shift[23:0], b};
                    n_asn_shift = asn_val;
                    if (r_asn_bytes_left != '0) begin
                        n_asn_bytes_left = r_asn_bytes_left - 10'd1;
                    end
                    // The ASN size may change mid-path, so close on any index at or past the end.
                    asn_close = r_asn_size_four ? (r_asn_byte_index == 2'd3)
                                                : (r_asn_byte_index != 2'd0);
                    if (asn_close) begin
                        if (asn_val[31:16] != 16'd0) begin
                            n_as4_flag = 1'b1;
                        end
                        if (r_segment_type == SEG_SEQ || r_segment_type == SEG_CONFED_SEQ) begin
                            n_origin_reg  = asn_val;
                            n_origin_flag = 1'b1;
                        end
                        if (r_segment_type == SEG_SEQ && r_segment_start == '0 &&
                            cur == (r_asn_size_four ? FIRST_END_AS4 : FIRST_END_AS2)) begin
                            n_first_reg  = asn_val;
                            n_first_flag = 1'b1;
                        end
                        n_asn_byte_index = '0;
                        n_asn_shift      = '0;
                    end else begin
                        n_asn_byte_index = r_asn_byte_index + 2'd1;
                    end
                    if (n_asn_bytes_left == '0) begin
                        if (n_latched_error == ERR_NONE && r_pending_error != ERR_NONE) begin
                            n_latched_error  = r_pending_error;
                            n_latched_value  = {5'd0, r_pending_value};
                            n_latched_offset = r_segment_start;
                        end
                        n_pending_error  = ERR_NONE;
                        n_pending_value  = '0;
                        n_asn_byte_index = '0;
                        n_asn_shift      = '0;
                        n_phase          = PH_TYPE;
                    end
                end
                default: begin
                    n_segment_type  = b;
                    n_segment_start = cur;
                    if (b == SEG_CONFED_SEQ || b == SEG_CONFED_SET) begin
                        n_confed_flag = 1'b1;
                    end
                    n_phase = PH_COUNT;
                end
            endcase
        end

        // A cut outranks the open segment's pending error but not an error already latched.
        if (i_item.last_byte && n_latched_error == ERR_NONE) begin
            if (n_phase == PH_COUNT) begin
                n_latched_error  = ERR_HDR_CUT;
                n_latched_value  = '0;
                n_latched_offset = n_segment_start;
            end else if (n_phase == PH_BODY) begin
                n_latched_error  = ERR_BODY_CUT;
                n_latched_value  = n_byte_offset - n_segment_start;
                n_latched_offset = n_segment_start;
            end
        end

        o_result.path_ok      = (n_latched_error == ERR_NONE);
        o_result.error_code   = n_latched_error;
        o_result.error_offset = (n_latched_error != ERR_NONE) ? n_latched_offset : '0;
        o_result.error_value  = (n_latched_error != ERR_NONE) ? n_latched_value : '0;
        o_result.path_length  = n_length_sum;
        o_result.origin_found = n_origin_flag;
        o_result.origin_as    = n_origin_flag ? n_origin_reg : '0;
        o_result.first_found  = n_first_flag;
        o_result.first_as     = n_first_flag ? n_first_reg : '0;
        o_result.has_confed   = n_confed_flag;
        o_result.has_as4      = n_as4_flag;

        if (i_item.last_byte) begin
            n_phase          = PH_TYPE;
            n_segment_type   = '0;
            n_asn_bytes_left = '0;
            n_asn_byte_index = '0;
            n_asn_shift      = '0;
            n_byte_offset    = '0;
            n_segment_start  = '0;
            n_pending_error  = ERR_NONE;
            n_pending_value  = '0;
            n_latched_error  = ERR_NONE;
            n_latched_value  = '0;
            n_latched_offset = '0;
            n_length_sum     = '0;
            n_origin_reg     = '0;
            n_origin_flag    = 1'b0;
            n_first_reg      = '0;
            n_first_flag     = 1'b0;
            n_confed_flag    = 1'b0;
            n_as4_flag       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asn_size_four  <= 1'b1;
            r_confed_allowed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ASN_SIZE_FOUR:  r_asn_size_four  <= i_cfg_wdata;
                CFG_CONFED_ALLOWED: r_confed_allowed <= i_cfg_wdata;
                default:            r_asn_size_four  <= r_asn_size_four;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_TYPE;
            r_segment_type   <= '0;
            r_asn_bytes_left <= '0;
            r_asn_byte_index <= '0;
            r_asn_shift      <= '0;
            r_byte_offset    <= '0;
            r_segment_start  <= '0;
            r_pending_error  <= ERR_NONE;
            r_pending_value  <= '0;
            r_latched_error  <= ERR_NONE;
            r_latched_value  <= '0;
            r_latched_offset <= '0;
            r_length_sum     <= '0;
            r_origin_reg     <= '0;
            r_origin_flag    <= 1'b0;
            r_first_reg      <= '0;
            r_first_flag     <= 1'b0;
            r_confed_flag    <= 1'b0;
            r_as4_flag       <= 1'b0;
        end else if (i_advance) begin
            r_phase          <= n_phase;
            r_segment_type   <= n_segment_type;
            r_asn_bytes_left <= n_asn_bytes_left;
            r_asn_byte_index <= n_asn_byte_index;
            r_asn_shift      <= n_asn_shift;
            r_byte_offset    <= n_byte_offset;
            r_segment_start  <= n_segment_start;
            r_pending_error  <= n_pending_error;
            r_pending_value  <= n_pending_value;
            r_latched_error  <= n_latched_error;
            r_latched_value  <= n_latched_value;
            r_latched_offset <= n_latched_offset;
            r_length_sum     <= n_length_sum;
            r_origin_reg     <= n_origin_reg;
            r_origin_flag    <= n_origin_flag;
            r_first_reg      <= n_first_reg;
            r_first_flag     <= n_first_flag;
            r_confed_flag    <= n_confed_flag;
            r_as4_flag       <= n_as4_flag;
        end
    end

endmodule

FILE: design/asp_out_stage.sv
// Result register of the AS path stream analyzer.
// Depends on asp_pkg for the result type.
module asp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  asp_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output asp_pkg::t_result o_result
);
    import asp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // A waiting result may be replaced in the cycle it is taken.
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: design/as_path_stream_analyzer.sv
// Top level of the AS path stream analyzer: BGP AS_PATH byte stream in, one result per path.
// Depends on asp_pkg, asp_in_stage, asp_parse_core, asp_out_stage and the assert header.
//
//   Port group   Direction  Payload
//   s_axis       in         tdata: data_byte; tuser: has_byte; tlast: last_byte
//   m_axis       out        tdata: one result per path (fields listed at the port)
//   i_cfg_*      in         register index and write data, written when i_cfg_we is high
//
// One item is taken per cycle unless the input is stalled. An accepted item waits in the input
// register until it is applied to the parser state; an item that closes a path loads its result
// into the output register at the edge that applies it, so m_axis_tvalid is registered. A closing
// item waits in the input register while the output register holds an untaken result, stalling
// the input; other items never wait on the output. Reset is synchronous and restores the
// configuration defaults and an empty path.
`include "as_path_stream_analyzer_assert.svh"

module as_path_stream_analyzer #(
    parameter int MAX_PATH_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic          s_axis_tuser,   // [0] has_byte
    input  logic          s_axis_tlast,   // last_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [0] path_ok, [3:1] error_code, [16:4] error_offset, [29:17] error_value,
    // [42:30] path_length, [43] origin_found, [75:44] origin_as, [76] first_found,
    // [108:77] first_as, [109] has_confed, [110] has_as4, [111] zero
    output logic [111:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic          i_cfg_wdata
);
    import asp_pkg::*;

    localparam int SAT_INT = (MAX_PATH_BYTES < OFFSET_FIELD_MAX) ?
                             MAX_PATH_BYTES : OFFSET_FIELD_MAX;
    localparam logic [12:0] SAT_CAP = 13'(SAT_INT);

    t_in_item w_s_item;
    t_in_item w_in_item;
    logic     w_in_valid;
    logic     w_advance;
    logic     w_out_free;
    t_result  w_core_result;
    t_result  w_out_result;

    assign w_s_item.data_byte = s_axis_tdata;
    assign w_s_item.has_byte  = s_axis_tuser;
    assign w_s_item.last_byte = s_axis_tlast;

    // Only an item that closes a path needs room in the output register.
    assign w_advance = w_in_valid && (!w_in_item.last_byte || w_out_free);

    asp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_s_item),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    asp_parse_core #(
        .MAX_PATH_BYTES (MAX_PATH_BYTES)
    ) u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_advance),
        .i_item      (w_in_item),
        .o_result    (w_core_result)
    );

    asp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_in_item.last_byte),
        .i_result (w_core_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = {1'b0, w_out_result};

    `ASP_ASSERT_IMPLY(a_ok_has_no_error, i_clk, i_rst_n,
        m_axis_tvalid && w_out_result.path_ok,
        (w_out_result.error_code == ERR_NONE) && (w_out_result.error_offset == '0) &&
        (w_out_result.error_value == '0),
        "passing path carries error details")
    `ASP_ASSERT_IMPLY(a_fail_has_code, i_clk, i_rst_n,
        m_axis_tvalid && !w_out_result.path_ok,
        (w_out_result.error_code != ERR_NONE) && (w_out_result.error_code <= ERR_ZERO_LEN),
        "failing path without a valid error code")
    `ASP_ASSERT_IMPLY(a_as_zero_unfound, i_clk, i_rst_n,
        m_axis_tvalid,
        (w_out_result.origin_found || w_out_result.origin_as == '0) &&
        (w_out_result.first_found || w_out_result.first_as == '0),
        "ASN reported without its found flag")
    `ASP_ASSERT_IMPLY(a_length_capped, i_clk, i_rst_n,
        m_axis_tvalid,
        (w_out_result.path_length <= SAT_CAP) && (w_out_result.error_offset <= SAT_CAP),
        "length or offset beyond saturation cap")
    `ASP_ASSERT_IMPLY(a_empty_input_ready, i_clk, i_rst_n,
        !w_in_valid, s_axis_tready,
        "input register empty but not ready")
    `ASP_ASSERT_NEXT(a_result_drains, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !(w_advance && w_in_item.last_byte),
        !m_axis_tvalid,
        "taken result shown again")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for as_path_stream_analyzer: streams AS_PATH bytes with bursty
// input and a stalling output, predicts every path result and compares it field by field.
// Depends on asp_pkg and the as_path_stream_analyzer RTL.
module tb;
    import asp_pkg::*;

    localparam int MAX_BYTES = 4096;
    localparam int PATH_CAP  = (MAX_BYTES < OFFSET_FIELD_MAX) ? MAX_BYTES : OFFSET_FIELD_MAX;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        SCAN_TYPE,
        SCAN_COUNT,
        SCAN_BODY
    } t_scan_phase;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = 1'b0;
    logic         i_cfg_wdata = 1'b0;

    as_path_stream_analyzer #(
        .MAX_PATH_BYTES(MAX_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and scoreboard storage.
    t_in_item    pending_items[$];
    t_result     expected_reports[$];
    logic [7:0]  path_bytes[$];

    int          stim_items = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          settings_used = 1;
    bit          noise_on = 1'b0;

    // Register copies used for prediction and stimulus shaping.
    logic        cfg_four = 1'b1;
    logic        cfg_confed = 1'b0;

    // Path analyzer state, mirroring the block.
    t_scan_phase scan_phase = SCAN_TYPE;
    logic [7:0]  seg_type = '0;
    logic [9:0]  body_left = '0;
    logic [1:0]  asn_idx = '0;
    logic [31:0] asn_acc = '0;
    logic [12:0] byte_offs = '0;
    logic [12:0] seg_start = '0;
    logic [2:0]  pend_err = ERR_NONE;
    logic [7:0]  pend_val = '0;
    logic [2:0]  first_err = ERR_NONE;
    logic [12:0] first_err_val = '0;
    logic [12:0] first_err_offs = '0;
    logic [12:0] len_sum = '0;
    logic [31:0] origin_asn = '0;
    logic        origin_ok = 1'b0;
    logic [31:0] lead_asn = '0;
    logic        lead_ok = 1'b0;
    logic        confed_seen = 1'b0;
    logic        as4_seen = 1'b0;

    // Sender and receiver pacing.
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_at = 32'hFFFF_FFFF;
    logic        long_hold = 1'b0;

    task clear_path();
        scan_phase = SCAN_TYPE; seg_type = '0; body_left = '0; asn_idx = '0;
        asn_acc = '0; byte_offs = '0; seg_start = '0; pend_err = ERR_NONE; pend_val = '0;
        first_err = ERR_NONE; first_err_val = '0; first_err_offs = '0; len_sum = '0;
        origin_asn = '0; origin_ok = 1'b0; lead_asn = '0; lead_ok = 1'b0;
        confed_seen = 1'b0; as4_seen = 1'b0;
    endtask

    // Only the first error of a path is kept.
    task note_error(logic [2:0] code, logic [12:0] value);
        if (first_err == ERR_NONE && code != ERR_NONE) begin
            first_err = code;
            first_err_val = value;
            first_err_offs = seg_start;
        end
    endtask

    task close_segment();
        note_error(pend_err, {5'd0, pend_val});
        pend_err = ERR_NONE; pend_val = '0;
        scan_phase = SCAN_TYPE; asn_idx = '0; asn_acc = '0; body_left = '0;
    endtask

    task add_length(int n);
        int s;
        s = int'(len_sum) + n;
        len_sum = (s < PATH_CAP) ? s[12:0] : PATH_CAP[12:0];
    endtask

    task take_asn(logic [31:0] asn, int cur, int size);
        if (asn > 32'h0000_FFFF) as4_seen = 1'b1;
        if (seg_type == SEG_SEQ || seg_type == SEG_CONFED_SEQ) begin
            origin_asn = asn;
            origin_ok = 1'b1;
        end
        if (seg_type == SEG_SEQ && seg_start == 0 && cur == 1 + size) begin
            lead_asn = asn;
            lead_ok = 1'b1;
        end
    endtask

    task consume_byte(logic [7:0] b);
        int cur;
        int size;
        cur = int'(byte_offs);
        size = cfg_four ? 4 : 2;
        byte_offs = (cur < PATH_CAP) ? 13'(cur + 1) : PATH_CAP[12:0];
        case (scan_phase)
            SCAN_COUNT: begin
                if (seg_type == SEG_SET || seg_type == SEG_SEQ)
                    pend_err = ERR_NONE;
                else if (seg_type == SEG_CONFED_SEQ || seg_type == SEG_CONFED_SET)
                    pend_err = cfg_confed ? ERR_NONE : ERR_CONFED;
                else
                    pend_err = ERR_UNKNOWN;
                if (pend_err == ERR_NONE && b == 0) pend_err = ERR_ZERO_LEN;
                pend_val = seg_type;
                if (seg_type == SEG_SET) add_length(1);
                else if (seg_type == SEG_SEQ) add_length(int'(b));
                if (b != 0 && (seg_type == SEG_SET || seg_type == SEG_CONFED_SET))
                    origin_ok = 1'b0;
                if (b == 0) begin
                    close_segment();
                end else begin
                    body_left = 10'(int'(b) * size);
                    asn_idx = '0;
                    asn_acc = '0;
                    scan_phase = SCAN_BODY;
                end
            end
            SCAN_BODY: begin
                asn_acc = {asn_acc[23:0], b};
                if (body_left > 0) body_left = body_left - 1'b1;
                // The ASN closes by the size in force now, even if it changed mid-segment.
                if (int'(asn_idx) + 1 >= size) begin
                    take_asn(asn_acc, cur, size);
                    asn_idx = '0;
                    asn_acc = '0;
                end else begin
                    asn_idx = asn_idx + 1'b1;
                end
                if (body_left == 0) close_segment();
            end
            default: begin
                seg_type = b;
                seg_start = cur[12:0];
                if (b == SEG_CONFED_SEQ || b == SEG_CONFED_SET) confed_seen = 1'b1;
                scan_phase = SCAN_COUNT;
            end
        endcase
    endtask

    task analyze_item(t_in_item it);
        t_result r;
        if (it.has_byte) consume_byte(it.data_byte);
        if (it.last_byte) begin
            // A cut framing outranks any error still pending in the open segment.
            if (scan_phase == SCAN_COUNT) note_error(ERR_HDR_CUT, '0);
            else if (scan_phase == SCAN_BODY) note_error(ERR_BODY_CUT, byte_offs - seg_start);
            r.path_ok = (first_err == ERR_NONE);
            r.error_code = first_err;
            r.error_offset = (first_err != ERR_NONE) ? first_err_offs : '0;
            r.error_value = (first_err != ERR_NONE) ? first_err_val : '0;
            r.path_length = len_sum;
            r.origin_found = origin_ok;
            r.origin_as = origin_ok ? origin_asn : '0;
            r.first_found = lead_ok;
            r.first_as = lead_ok ? lead_asn : '0;
            r.has_confed = confed_seen;
            r.has_as4 = as4_seen;
            expected_reports.push_back(r);
            clear_path();
        end
    endtask

    // Sender: bursts of items with random gaps between them.
    always @(posedge i_clk) begin : drive_proc
        t_in_item nxt;
        bit       v;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            v = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                analyze_item('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
                v = 1'b0;
            end
            if (!v) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    s_axis_tdata <= nxt.data_byte;
                    s_axis_tuser <= nxt.has_byte;
                    s_axis_tlast <= nxt.last_byte;
                    v = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_axis_tvalid <= v;
        end
    end

    // Long output hold-off, counted here so the sender keeps pushing while it lasts.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        long_hold <= (cycle_count >= hold_at) && (cycle_count - hold_at < LONG_HOLD_CYCLES);
    end

    // Receiver: a stall pattern that changes mode every so often.
    always @(posedge i_clk) begin : rx_pattern
        bit rdy;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 150);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 1) == 1);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ($urandom_range(0, 9) != 0);
        endcase
        m_axis_tready <= rdy && !long_hold;
    end

    task check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[110:0]);
            if (expected_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result 0x%0h with nothing expected", m_axis_tdata);
            end else begin
                want = expected_reports.pop_front();
                check_field("path_ok", 32'(want.path_ok), 32'(got.path_ok));
                check_field("error_code", 32'(want.error_code), 32'(got.error_code));
                check_field("error_offset", 32'(want.error_offset), 32'(got.error_offset));
                check_field("error_value", 32'(want.error_value), 32'(got.error_value));
                check_field("path_length", 32'(want.path_length), 32'(got.path_length));
                check_field("origin_found", 32'(want.origin_found), 32'(got.origin_found));
                check_field("origin_as", want.origin_as, got.origin_as);
                check_field("first_found", 32'(want.first_found), 32'(got.first_found));
                check_field("first_as", want.first_as, got.first_as);
                check_field("has_confed", 32'(want.has_confed), 32'(got.has_confed));
                check_field("has_as4", 32'(want.has_as4), 32'(got.has_as4));
            end
            results_seen++;
        end
    end

    task push_item(logic [7:0] b, logic has, logic last);
        t_in_item it;
        if (noise_on && $urandom_range(0, 11) == 0) begin
            it.data_byte = 8'($urandom);
            it.has_byte = 1'b0;
            it.last_byte = 1'b0;
            pending_items.push_back(it);
            stim_items++;
        end
        it.data_byte = b;
        it.has_byte = has;
        it.last_byte = last;
        pending_items.push_back(it);
        stim_items++;
    endtask

    // Queue the bytes in path_bytes, closing the path on its final byte or by an end mark.
    task send_path(bit end_on_byte);
        int n;
        n = path_bytes.size();
        for (int i = 0; i < n; i++)
            push_item(path_bytes[i], 1'b1, end_on_byte && i == n - 1);
        if (!end_on_byte || n == 0) push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task send_open(logic [7:0] b);
        path_bytes.push_back(b);
    endtask

    function automatic logic [31:0] random_asn();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_FFFF;
                    2: return 32'h0001_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed segments with random content; some garbage and truncated paths.
    task make_path();
        int         nseg;
        int         cnt;
        int         size;
        int         r;
        int         cut;
        logic [7:0] t;
        logic [31:0] asn;
        path_bytes.delete();
        size = cfg_four ? 4 : 2;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) path_bytes.push_back(8'($urandom));
            return;
        end
        nseg = $urandom_range(0, 4);
        repeat (nseg) begin
            t = ($urandom_range(0, 19) < 17) ? 8'($urandom_range(1, 4)) : 8'($urandom);
            r = $urandom_range(0, 19);
            cnt = (r == 0) ? 0 : ((r == 1) ? $urandom_range(6, 40) : $urandom_range(1, 4));
            path_bytes.push_back(t);
            path_bytes.push_back(cnt[7:0]);
            repeat (cnt) begin
                asn = random_asn();
                for (int k = size - 1; k >= 0; k--) path_bytes.push_back(asn[8*k +: 8]);
            end
        end
        if (path_bytes.size() > 0 && $urandom_range(0, 6) == 0) begin
            cut = $urandom_range(0, path_bytes.size() - 1);
            while (path_bytes.size() > cut) void'(path_bytes.pop_back());
        end
    endtask

    task wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        // Covers the input and output registers of the block.
        repeat (6) @(posedge i_clk);
    endtask

    task write_cfg(logic addr, logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_ASN_SIZE_FOUR) cfg_four = val;
        else cfg_confed = val;
    endtask

    task set_mode(logic four, logic confed);
        write_cfg(CFG_ASN_SIZE_FOUR, four);
        write_cfg(CFG_CONFED_ALLOWED, confed);
        settings_used++;
    endtask

    initial begin
        int phase_idx;
        int phase_start;
        int random_start;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset settings: four-byte ASNs, confederations forbidden.
        push_item(8'hA5, 1'b0, 1'b0);
        path_bytes.delete();
        send_path(0);
        path_bytes = '{SEG_SEQ, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_path(1);
        path_bytes = '{SEG_CONFED_SEQ, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        send_path(0);
        path_bytes = '{SEG_SET};
        send_path(1);
        // Body cut while an unknown-type error is pending: the cut wins.
        path_bytes = '{8'h07, 8'h01, 8'h00};
        send_path(1);
        wait_idle();

        set_mode(1'b0, 1'b1);
        path_bytes = '{SEG_CONFED_SET, 8'h01, 8'h12, 8'h34, SEG_SEQ, 8'h00,
                       SEG_SET, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h01, 8'hAB, 8'hCD};
        send_path(0);
        path_bytes = '{8'h00, 8'h01, 8'hFF, 8'hFF};
        send_path(1);
        wait_idle();
        // ASN size switched in the middle of a segment body.
        path_bytes = '{SEG_SEQ, 8'h02, 8'h12, 8'h34};
        foreach (path_bytes[i]) push_item(path_bytes[i], 1'b1, 1'b0);
        wait_idle();
        write_cfg(CFG_ASN_SIZE_FOUR, 1'b1);
        path_bytes = '{8'h56, 8'h78};
        send_path(0);
        wait_idle();

        // Random part: one register setting per phase, all four combinations first.
        noise_on = 1'b1;
        random_start = stim_items;
        phase_idx = 0;
        while (stim_items - random_start < 800) begin
            if (phase_idx < 4) set_mode(phase_idx[1], phase_idx[0]);
            else set_mode($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
            phase_start = stim_items;
            while (stim_items - phase_start < 120 && stim_items - random_start < 800) begin
                make_path();
                send_path($urandom_range(0, 1) == 1);
            end
            if (phase_idx == 0) hold_at = cycle_count + 30;
            wait_idle();
            phase_idx++;
        end

        $display("Sent %0d items, checked %0d path results across %0d register settings,",
                 stim_items, results_seen, settings_used);
        $display("including truncated and garbage paths and a %0d-cycle output hold-off.",
                 LONG_HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results still expected", expected_reports.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/asp_pkg.sv
design/asp_in_stage.sv
design/asp_parse_core.sv
design/asp_out_stage.sv
design/as_path_stream_analyzer.sv
tb/tb.sv
